// ----- rtl/core/cpu_alu_with_flags_core_defines.svh -----
// assertion macros used by the bound checker module
`ifndef CPU_ALU_WITH_FLAGS_CORE_DEFINES_SVH
`define CPU_ALU_WITH_FLAGS_CORE_DEFINES_SVH

// clocked assertion, off while reset is high
`define CPUALU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define CPUALU_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/cpualu_pkg.sv -----
package cpualu_pkg;

  // operation codes
  localparam logic [4:0] OP_ADD    = 5'd0;
  localparam logic [4:0] OP_ADC    = 5'd1;
  localparam logic [4:0] OP_SUB    = 5'd2;
  localparam logic [4:0] OP_SBC    = 5'd3;
  localparam logic [4:0] OP_AND    = 5'd4;
  localparam logic [4:0] OP_OR     = 5'd5;
  localparam logic [4:0] OP_EOR    = 5'd6;
  localparam logic [4:0] OP_PASS8  = 5'd7;
  localparam logic [4:0] OP_NEG    = 5'd8;
  localparam logic [4:0] OP_COM    = 5'd9;
  localparam logic [4:0] OP_LSR    = 5'd10;
  localparam logic [4:0] OP_ROR    = 5'd11;
  localparam logic [4:0] OP_ASR    = 5'd12;
  localparam logic [4:0] OP_ASL    = 5'd13;
  localparam logic [4:0] OP_ROL    = 5'd14;
  localparam logic [4:0] OP_INC    = 5'd15;
  localparam logic [4:0] OP_DEC    = 5'd16;
  localparam logic [4:0] OP_CLR    = 5'd17;
  localparam logic [4:0] OP_DAA    = 5'd18;
  localparam logic [4:0] OP_MUL    = 5'd19;
  localparam logic [4:0] OP_SEX    = 5'd20;
  localparam logic [4:0] OP_ADD16  = 5'd21;
  localparam logic [4:0] OP_SUB16  = 5'd22;
  localparam logic [4:0] OP_PASS16 = 5'd23;

  // condition-code bit positions
  localparam int unsigned CC_C = 0;
  localparam int unsigned CC_V = 1;
  localparam int unsigned CC_Z = 2;
  localparam int unsigned CC_N = 3;
  localparam int unsigned CC_H = 5;

  // first stage: operands plus adder inputs
  typedef struct packed {
    logic [4:0]  mode;
    logic [15:0] wa;
    logic [15:0] wb;
    logic [7:0]  cc;
    logic [16:0] x;
    logic [16:0] y;
    logic        cin;
  } s1_t;

  // second stage: operands plus raw result with carry bit
  typedef struct packed {
    logic [4:0]  mode;
    logic [15:0] wa;
    logic [15:0] wb;
    logic [7:0]  cc;
    logic [16:0] r;
  } s2_t;

endpackage

// ----- rtl/core/cpualu_if.sv -----
// operation word channel
interface cpualu_req_if;
  logic        valid;
  logic        ready;
  logic [4:0]  mode;
  logic [15:0] operand_a;
  logic [15:0] operand_b;
  logic [7:0]  cc_in;

  modport source (output valid, mode, operand_a, operand_b, cc_in, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, cc_in, output ready);
endinterface

// result word channel
interface cpualu_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result;
  logic [7:0]  cc_out;

  modport source (output valid, result, cc_out, input ready);
  modport sink   (input valid, result, cc_out, output ready);
endinterface

// ----- rtl/core/cpu_alu_with_flags_core.sv -----
// Condition-code ALU of an 8-bit processor, three register stages deep: operand and
// adder-input selection (with the decimal-adjust correction) ahead of the first
// register, the 17-bit adder, 8x8 multiplier, logic and shifts ahead of the second,
// and the condition-code update ahead of the third, which is the output register.
// A word is accepted every cycle while ready is high; each result passes the first and
// second registers and then the output register, where it waits while the result side
// holds ready low. Ready drops only while the output register holds a word that is not
// taken and every stage behind it is full.
module cpu_alu_with_flags_core (
  input  logic               clk,
  input  logic               rst,
  cpualu_req_if.sink         req,
  cpualu_rsp_if.source       rsp
);
  import cpualu_pkg::*;

  logic        v1;
  logic        v2;
  logic        v3;
  logic        en1;
  logic        en2;
  logic        en3;
  s1_t         s1;
  s1_t         s1_next;
  s2_t         s2;
  s2_t         s2_next;
  logic [15:0] res;
  logic [7:0]  cc;
  logic [15:0] res_next;
  logic [7:0]  cc_next;

  // stage enables, a stage moves when the one ahead has room
  assign en3       = !v3 || rsp.ready;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign req.ready = en1;

  // adder input selection and decimal-adjust correction
  always_comb begin
    logic [7:0] a;
    logic [7:0] b;
    logic       c;
    logic [7:0] fix;
    a   = req.operand_a[7:0];
    b   = req.operand_b[7:0];
    c   = req.cc_in[CC_C];
    fix = 8'h00;
    if (req.cc_in[CC_H] || a[3:0] > 4'd9) begin
      fix[3:0] = 4'h6;
    end
    if (c || a[7:4] > 4'd9 || (a[7:4] > 4'd8 && a[3:0] > 4'd9)) begin
      fix[7:4] = 4'h6;
    end
    s1_next.mode = req.mode;
    s1_next.wa   = req.operand_a;
    s1_next.wb   = req.operand_b;
    s1_next.cc   = req.cc_in;
    s1_next.x    = {9'h000, a};
    s1_next.y    = 17'h00000;
    s1_next.cin  = 1'b0;
    unique case (req.mode)
      OP_ADD: s1_next.y = {9'h000, b};
      OP_ADC: begin
        s1_next.y   = {9'h000, b};
        s1_next.cin = c;
      end
      OP_SUB: begin
        s1_next.y   = ~{9'h000, b};
        s1_next.cin = 1'b1;
      end
      OP_SBC: begin
        s1_next.y   = ~{9'h000, b};
        s1_next.cin = !c;
      end
      OP_NEG: begin
        s1_next.x   = 17'h00000;
        s1_next.y   = ~{9'h000, a};
        s1_next.cin = 1'b1;
      end
      OP_ASL: s1_next.y = {9'h000, a};
      OP_INC: s1_next.cin = 1'b1;
      OP_DEC: s1_next.y = 17'h1ffff;
      OP_DAA: s1_next.y = {9'h000, fix};
      OP_ADD16: begin
        s1_next.x = {1'b0, req.operand_a};
        s1_next.y = {1'b0, req.operand_b};
      end
      OP_SUB16: begin
        s1_next.x   = {1'b0, req.operand_a};
        s1_next.y   = ~{1'b0, req.operand_b};
        s1_next.cin = 1'b1;
      end
      default: s1_next.y = 17'h00000;
    endcase
  end

  // adder, multiplier, logic and shifts
  always_comb begin
    logic [7:0]  a;
    logic [7:0]  b;
    logic        c;
    logic [16:0] sum;
    logic [15:0] prod;
    a    = s1.wa[7:0];
    b    = s1.wb[7:0];
    c    = s1.cc[CC_C];
    sum  = s1.x + s1.y + {16'h0000, s1.cin};
    prod = {8'h00, a} * {8'h00, b};
    s2_next.mode = s1.mode;
    s2_next.wa   = s1.wa;
    s2_next.wb   = s1.wb;
    s2_next.cc   = s1.cc;
    unique case (s1.mode)
      OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_NEG, OP_ASL, OP_INC, OP_DEC, OP_DAA,
      OP_ADD16, OP_SUB16: s2_next.r = sum;
      OP_AND:    s2_next.r = {9'h000, a & b};
      OP_OR:     s2_next.r = {9'h000, a | b};
      OP_EOR:    s2_next.r = {9'h000, a ^ b};
      OP_PASS8:  s2_next.r = {9'h000, b};
      OP_COM:    s2_next.r = {9'h000, ~a};
      OP_LSR:    s2_next.r = {9'h000, 1'b0, a[7:1]};
      OP_ROR:    s2_next.r = {9'h000, c, a[7:1]};
      OP_ASR:    s2_next.r = {9'h000, a[7], a[7:1]};
      OP_ROL:    s2_next.r = {9'h000, a[6:0], c};
      OP_CLR:    s2_next.r = 17'h00000;
      OP_MUL:    s2_next.r = {1'b0, prod};
      OP_SEX:    s2_next.r = {1'b0, {8{a[7]}}, a};
      OP_PASS16: s2_next.r = {1'b0, s1.wb};
      default:   s2_next.r = 17'h00000;
    endcase
  end

  // condition codes and final result
  cpualu_flags u_flags (
    .st     (s2),
    .result (res_next),
    .cc_out (cc_next)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= req.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en1 && req.valid) s1 <= s1_next;
    if (en2 && v1) s2 <= s2_next;
    if (en3 && v2) begin
      res <= res_next;
      cc  <= cc_next;
    end
  end

  assign rsp.valid  = v3;
  assign rsp.result = res;
  assign rsp.cc_out = cc;

endmodule

// ----- rtl/core/cpualu_flags.sv -----
module cpualu_flags (
  input  cpualu_pkg::s2_t st,
  output logic [15:0]     result,
  output logic [7:0]      cc_out
);
  import cpualu_pkg::*;

  // condition-code update from the raw result
  always_comb begin
    logic [7:0] a;
    logic [7:0] fa;
    logic [7:0] fb;
    logic [7:0] r8;
    logic [7:0] cc;
    a  = st.wa[7:0];
    r8 = st.r[7:0];
    fa = a;
    fb = st.wb[7:0];
    cc = st.cc;
    unique case (st.mode)
      OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_NEG, OP_ASL: begin
        if (st.mode == OP_NEG) begin
          fa = 8'h00;
          fb = a;
        end else if (st.mode == OP_ASL) begin
          fb = a;
        end
        cc[CC_H] = fa[4] ^ fb[4] ^ r8[4];
        cc[CC_V] = fa[7] ^ fb[7] ^ r8[7] ^ st.r[8];
        cc[CC_C] = st.r[8];
        cc[CC_Z] = (r8 == 8'h00);
        cc[CC_N] = r8[7];
      end
      OP_AND, OP_OR, OP_EOR, OP_PASS8: begin
        cc[CC_V] = 1'b0;
        cc[CC_Z] = (r8 == 8'h00);
        cc[CC_N] = r8[7];
      end
      OP_COM: begin
        cc[CC_C] = 1'b1;
        cc[CC_V] = 1'b0;
        cc[CC_Z] = (r8 == 8'h00);
        cc[CC_N] = r8[7];
      end
      OP_LSR, OP_ROR, OP_ASR: begin
        cc[CC_C] = a[0];
        cc[CC_Z] = (r8 == 8'h00);
        cc[CC_N] = r8[7];
      end
      OP_ROL: begin
        cc[CC_C] = a[7];
        cc[CC_V] = a[7] ^ a[6];
        cc[CC_Z] = (r8 == 8'h00);
        cc[CC_N] = r8[7];
      end
      OP_INC, OP_DEC: begin
        cc[CC_V] = (st.mode == OP_INC) ? (r8 == 8'h80) : (r8 == 8'h7f);
        cc[CC_Z] = (r8 == 8'h00);
        cc[CC_N] = r8[7];
      end
      OP_CLR: begin
        cc[CC_N] = 1'b0;
        cc[CC_V] = 1'b0;
        cc[CC_Z] = 1'b1;
        cc[CC_C] = 1'b0;
      end
      OP_DAA: begin
        cc[CC_C] = st.cc[CC_C] | st.r[8];
        cc[CC_V] = 1'b0;
        cc[CC_Z] = (r8 == 8'h00);
        cc[CC_N] = r8[7];
      end
      OP_MUL: begin
        cc[CC_Z] = (st.r[15:0] == 16'h0000);
        cc[CC_C] = st.r[7];
      end
      OP_SEX: begin
        cc[CC_Z] = (st.r[15:0] == 16'h0000);
        cc[CC_N] = st.r[15];
      end
      OP_ADD16, OP_SUB16: begin
        cc[CC_C] = st.r[16];
        cc[CC_V] = st.r[16] ^ st.wa[15] ^ st.wb[15] ^ st.r[15];
        cc[CC_Z] = (st.r[15:0] == 16'h0000);
        cc[CC_N] = st.r[15];
      end
      OP_PASS16: begin
        cc[CC_V] = 1'b0;
        cc[CC_Z] = (st.r[15:0] == 16'h0000);
        cc[CC_N] = st.r[15];
      end
      default: begin
        cc = st.cc;
      end
    endcase
    cc_out = cc;
  end

  // byte operations leave the upper byte clear
  assign result = (st.mode <= OP_DAA) ? {8'h00, st.r[7:0]} : st.r[15:0];

endmodule

// ----- rtl/core/cpualu_chk.sv -----
`include "cpu_alu_with_flags_core_defines.svh"

module cpualu_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] result,
  input logic [7:0]  cc_out
);

  logic in_take;
  logic out_stall;

  assign in_take   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // pipeline empties on reset
  `CPUALU_ASSERT_RST(a_rst_empty, rst |=> !out_valid, "output valid after reset")

  // a held word stays put
  `CPUALU_ASSERT(a_hold, out_stall |=> out_valid && $stable({result, cc_out}), "word changed")

  // input side only stalls when the output stalls
  `CPUALU_ASSERT(a_ready, !out_stall |-> in_ready, "input stalled without output stall")

  // a taken word reaches the output when the output side keeps taking words
  `CPUALU_ASSERT(a_latency, in_take ##1 out_ready ##1 out_ready |=> out_valid, "late result")

endmodule

bind cpu_alu_with_flags_core cpualu_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .result    (rsp.result),
  .cc_out    (rsp.cc_out)
);

// ----- dv/alu_flags_checker.sv -----
`timescale 1ns / 1ps

module alu_flags_checker (
  input  logic        clk,
  input  logic        rst,
  cpualu_req_if       req,
  cpualu_rsp_if       rsp,
  output int unsigned fail_count,
  output int unsigned pending
);
  import cpualu_pkg::*;

  // one predicted result word, with the operation kept for messages
  typedef struct packed {
    logic [4:0]  mode;
    logic [15:0] result;
    logic [7:0]  cc_out;
  } alu_word_t;

  alu_word_t   expected_words[$];
  int unsigned fails = 0;

  // n and z from a result byte
  function automatic logic [7:0] set_nz8(logic [7:0] cc, logic [7:0] r);
    logic [7:0] f;
    f = cc;
    f[CC_Z] = (r == 8'h00);
    f[CC_N] = r[7];
    return f;
  endfunction

  // n and z from a result halfword
  function automatic logic [7:0] set_nz16(logic [7:0] cc, logic [15:0] r);
    logic [7:0] f;
    f = cc;
    f[CC_Z] = (r == 16'h0000);
    f[CC_N] = r[15];
    return f;
  endfunction

  // h, v, c, n, z for 8-bit binary arithmetic; r carries the borrow or carry in bit 8
  function automatic logic [7:0] flags8(logic [7:0] cc, logic [7:0] a, logic [7:0] b,
                                        logic [8:0] r);
    logic [7:0] f;
    logic [7:0] x;
    x = a ^ b ^ r[7:0];
    f = cc;
    f[CC_H] = x[4];
    f[CC_V] = x[7] ^ r[8];
    f[CC_C] = r[8];
    return set_nz8(f, r[7:0]);
  endfunction

  // v, c, n, z for 16-bit add and subtract, h untouched
  function automatic logic [7:0] flags16(logic [7:0] cc, logic [15:0] a, logic [15:0] b,
                                         logic [16:0] r);
    logic [7:0]  f;
    logic [15:0] x;
    x = a ^ b ^ r[15:0];
    f = cc;
    f[CC_C] = r[16];
    f[CC_V] = x[15] ^ r[16];
    return set_nz16(f, r[15:0]);
  endfunction

  // expected result word for one operation word
  function automatic alu_word_t alu_flags_predict(logic [4:0] mode, logic [15:0] wa,
                                                  logic [15:0] wb, logic [7:0] cc_in);
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  cc;
    logic [7:0]  fix;
    logic [7:0]  r8;
    logic [8:0]  r9;
    logic [15:0] p;
    logic [16:0] r17;
    logic        cin;
    alu_word_t   w;
    a   = wa[7:0];
    b   = wb[7:0];
    cc  = cc_in;
    cin = cc_in[CC_C];
    r8  = 8'h00;
    w.mode   = mode;
    w.result = 16'h0000;
    case (mode)
      OP_ADD: begin
        r9 = {1'b0, a} + {1'b0, b};
        cc = flags8(cc, a, b, r9);
        r8 = r9[7:0];
      end
      OP_ADC: begin
        r9 = {1'b0, a} + {1'b0, b} + {8'h00, cin};
        cc = flags8(cc, a, b, r9);
        r8 = r9[7:0];
      end
      OP_SUB: begin
        r9 = {1'b0, a} - {1'b0, b};
        cc = flags8(cc, a, b, r9);
        r8 = r9[7:0];
      end
      OP_SBC: begin
        r9 = {1'b0, a} - {1'b0, b} - {8'h00, cin};
        cc = flags8(cc, a, b, r9);
        r8 = r9[7:0];
      end
      OP_AND, OP_OR, OP_EOR, OP_PASS8: begin
        case (mode)
          OP_AND:  r8 = a & b;
          OP_OR:   r8 = a | b;
          OP_EOR:  r8 = a ^ b;
          default: r8 = b;
        endcase
        cc = set_nz8(cc, r8);
        cc[CC_V] = 1'b0;
      end
      OP_NEG: begin
        r9 = 9'd0 - {1'b0, a};
        cc = flags8(cc, 8'h00, a, r9);
        r8 = r9[7:0];
      end
      OP_COM: begin
        r8 = ~a;
        cc = set_nz8(cc, r8);
        cc[CC_C] = 1'b1;
        cc[CC_V] = 1'b0;
      end
      OP_LSR, OP_ROR, OP_ASR: begin
        case (mode)
          OP_LSR:  r8 = {1'b0, a[7:1]};
          OP_ROR:  r8 = {cin, a[7:1]};
          default: r8 = {a[7], a[7:1]};
        endcase
        cc[CC_C] = a[0];
        cc = set_nz8(cc, r8);
      end
      OP_ASL: begin
        r9 = {a, 1'b0};
        cc = flags8(cc, a, a, r9);
        r8 = r9[7:0];
      end
      OP_ROL: begin
        r8 = {a[6:0], cin};
        cc[CC_C] = a[7];
        cc[CC_V] = a[7] ^ a[6];
        cc = set_nz8(cc, r8);
      end
      OP_INC: begin
        r8 = a + 8'd1;
        cc[CC_V] = (r8 == 8'h80);
        cc = set_nz8(cc, r8);
      end
      OP_DEC: begin
        r8 = a - 8'd1;
        cc[CC_V] = (r8 == 8'h7f);
        cc = set_nz8(cc, r8);
      end
      OP_CLR: begin
        r8 = 8'h00;
        cc[CC_N] = 1'b0;
        cc[CC_V] = 1'b0;
        cc[CC_Z] = 1'b1;
        cc[CC_C] = 1'b0;
      end
      OP_DAA: begin
        // low correction on half carry or a bad low digit; high on carry, a bad high digit, or 9 above a bad low digit
        fix = 8'h00;
        if (cc_in[CC_H] || a[3:0] > 4'd9) fix[3:0] = 4'h6;
        if (cin || a[7:4] > 4'd9 || (a[7:4] > 4'd8 && a[3:0] > 4'd9)) fix[7:4] = 4'h6;
        r9 = {1'b0, a} + {1'b0, fix};
        cc[CC_C] = cin | r9[8];
        r8 = r9[7:0];
        cc = set_nz8(cc, r8);
        cc[CC_V] = 1'b0;
      end
      OP_MUL: begin
        p = {8'h00, a} * {8'h00, b};
        cc[CC_Z] = (p == 16'h0000);
        cc[CC_C] = p[7];
        w.result = p;
      end
      OP_SEX: begin
        p = {{8{a[7]}}, a};
        cc = set_nz16(cc, p);
        w.result = p;
      end
      OP_ADD16: begin
        r17 = {1'b0, wa} + {1'b0, wb};
        cc = flags16(cc, wa, wb, r17);
        w.result = r17[15:0];
      end
      OP_SUB16: begin
        r17 = {1'b0, wa} - {1'b0, wb};
        cc = flags16(cc, wa, wb, r17);
        w.result = r17[15:0];
      end
      OP_PASS16: begin
        cc = set_nz16(cc, wb);
        cc[CC_V] = 1'b0;
        w.result = wb;
      end
      default: begin
        // unused codes: zero result, flags pass through
        w.result = 16'h0000;
      end
    endcase
    if (mode <= OP_DAA) w.result = {8'h00, r8};
    w.cc_out = cc;
    return w;
  endfunction

  // match each result word against the oldest prediction, then queue new operations
  always @(posedge clk) begin
    alu_word_t want;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: result %h cc_out %h",
                 rsp.result, rsp.cc_out);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (rsp.result !== want.result) begin
            $error("result (mode %0d): expected %h, actual %h",
                   want.mode, want.result, rsp.result);
            fails++;
          end
          if (rsp.cc_out !== want.cc_out) begin
            $error("cc_out (mode %0d): expected %h, actual %h",
                   want.mode, want.cc_out, rsp.cc_out);
            fails++;
          end
        end
      end
      if (req.valid && req.ready)
        expected_words.push_back(alu_flags_predict(req.mode, req.operand_a,
                                                   req.operand_b, req.cc_in));
    end
    pending    <= expected_words.size();
    fail_count <= fails;
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import cpualu_pkg::*;

  // last code, past the defined operations
  localparam logic [4:0] OP_UNUSED_HI = 5'd31;

  localparam int RANDOM_WORDS = 1750;
  localparam int CALM_TAIL    = 250;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sink_ready = 1'b0;
  bit          idle_en = 1'b1;
  int          stall_left = 0;
  int unsigned fail_count;
  int unsigned pending;

  cpualu_req_if req_ch();
  cpualu_rsp_if rsp_ch();

  cpu_alu_with_flags_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  alu_flags_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  assign rsp_ch.ready = sink_ready;

  // result side: random stall bursts while idling is enabled
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= 1'b0;
    end else if (idle_en && !rst && $urandom_range(0, 7) == 0) begin
      stall_left <= int'($urandom_range(0, 10));
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // present one operation word, with an occasional idle burst ahead of it
  task automatic send_word(input logic [4:0] mode, input logic [15:0] a,
                           input logic [15:0] b, input logic [7:0] cc);
    int gap;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      gap = int'($urandom_range(1, 11));
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.mode      <= mode;
    req_ch.operand_a <= a;
    req_ch.operand_b <= b;
    req_ch.cc_in     <= cc;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // operands leaning toward the carry and sign boundaries
  function automatic logic [15:0] pick_operand();
    logic [7:0]  hi;
    logic [15:0] v;
    hi = 8'($urandom);
    case ($urandom_range(0, 13))
      0:       v = 16'h0000;
      1:       v = 16'hffff;
      2:       v = 16'h7fff;
      3:       v = 16'h8000;
      4:       v = {hi, 8'h7f};
      5:       v = {hi, 8'h80};
      6:       v = {hi, 8'hff};
      7:       v = {hi, 8'h00};
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // watchdog
  initial begin
    #5_000_000;
    $display("cpu_alu_with_flags_core regression: fail");
    $finish;
  end

  initial begin
    logic [4:0] mode;
    req_ch.valid     <= 1'b0;
    req_ch.mode      <= OP_ADD;
    req_ch.operand_a <= 16'h0000;
    req_ch.operand_b <= 16'h0000;
    req_ch.cc_in     <= 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: flag boundaries of each operation
    send_word(OP_ADD,    16'h12ff, 16'hab01, 8'h00);  // carry, zero, half carry
    send_word(OP_ADC,    16'h007f, 16'h0000, 8'h01);  // overflow through carry in
    send_word(OP_SUB,    16'h0080, 16'h0001, 8'hd0);  // signed overflow
    send_word(OP_SBC,    16'h0000, 16'h0000, 8'h01);  // borrow from carry in
    send_word(OP_AND,    16'hfff0, 16'h0f0f, 8'hff);
    send_word(OP_OR,     16'h0000, 16'hff00, 8'h02);  // zero low byte
    send_word(OP_EOR,    16'h00ff, 16'h0055, 8'h00);
    send_word(OP_PASS8,  16'h1234, 16'hff80, 8'h02);
    send_word(OP_NEG,    16'h0080, 16'h0000, 8'h00);  // negating the most negative byte
    send_word(OP_COM,    16'hff00, 16'h0000, 8'h02);
    send_word(OP_LSR,    16'h0001, 16'h0000, 8'h08);
    send_word(OP_ROR,    16'h0001, 16'h0000, 8'h01);  // carry rotates into the sign
    send_word(OP_ASR,    16'h0081, 16'h0000, 8'h00);  // sign bit kept
    send_word(OP_ASL,    16'h00c0, 16'h0000, 8'h00);
    send_word(OP_ROL,    16'h0040, 16'h0000, 8'h01);  // overflow from bits 7 and 6
    send_word(OP_INC,    16'h007f, 16'h0000, 8'h01);
    send_word(OP_DEC,    16'h0080, 16'h0000, 8'h00);
    send_word(OP_CLR,    16'hffff, 16'hffff, 8'hff);
    send_word(OP_DAA,    16'h009a, 16'h0000, 8'h20);  // both digits corrected
    send_word(OP_MUL,    16'hffff, 16'hffff, 8'h04);  // largest product
    send_word(OP_SEX,    16'h0080, 16'h0000, 8'h00);
    send_word(OP_ADD16,  16'hffff, 16'h0001, 8'h00);  // 16-bit carry and zero
    send_word(OP_SUB16,  16'h8000, 16'h0001, 8'h00);  // 16-bit overflow
    send_word(OP_PASS16, 16'hffff, 16'h0000, 8'h0a);
    send_word(OP_UNUSED_HI, 16'hffff, 16'hffff, 8'hff);

    // random words, with stretches free of idling and a calm tail
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      idle_en <= (i < RANDOM_WORDS - CALM_TAIL) && ((i % 500) < 400);
      if ($urandom_range(0, 9) == 0)
        mode = 5'($urandom_range(OP_ADD, OP_UNUSED_HI));
      else
        mode = 5'($urandom_range(OP_ADD, OP_PASS16));
      send_word(mode, pick_operand(), pick_operand(), 8'($urandom));
    end
    req_ch.valid <= 1'b0;

    // drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("cpu_alu_with_flags_core regression: pass");
    else
      $display("cpu_alu_with_flags_core regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/cpualu_pkg.sv
rtl/core/cpualu_if.sv
rtl/core/cpualu_flags.sv
rtl/core/cpu_alu_with_flags_core.sv
rtl/core/cpualu_chk.sv
dv/alu_flags_checker.sv
dv/tb_top.sv
